FILE: design/popq_pkg.sv
// Shared constants, types and helper functions for the path oblivious priority queue.
package popq_pkg;

    // Tree shape and slot counts.
    localparam int LEVELS       = 10;
    localparam int LEAVES       = 1 << LEVELS;
    localparam int NODES        = 2 * LEAVES - 1;
    localparam int BUCKET_SLOTS = 4;
    localparam int ROOT_SLOTS   = 8;
    localparam int GATHER_MAX   = 2 * LEVELS * BUCKET_SLOTS + ROOT_SLOTS + 1;

    // Field and index widths.
    localparam int PRIO_W     = 31;
    localparam int LEAF_W     = LEVELS;
    localparam int NODE_W     = LEVELS + 1;
    localparam int DEPTH_W    = $clog2(LEVELS + 1);
    localparam int SLOT_W     = $clog2(ROOT_SLOTS + 1);
    localparam int ROOT_IDX_W = $clog2(ROOT_SLOTS);
    localparam int BKT_IDX_W  = $clog2(BUCKET_SLOTS);
    localparam int GIDX_W     = $clog2(GATHER_MAX + 1);
    localparam int USED_W     = 4;

    // Priority of an empty minimum.
    localparam logic [PRIO_W-1:0] PRIO_NONE = {PRIO_W{1'b1}};

    // One stored element: priority (zero marks an empty slot) and its leaf.
    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [LEAF_W-1:0] lf;
    } elem_t;

    // One bucket row holds all slots of a non-root node.
    typedef elem_t [BUCKET_SLOTS-1:0] row_t;

    // Command beat.
    typedef struct packed {
        logic              mode;
        logic [PRIO_W-1:0] priority_req;
        logic [LEAF_W-1:0] leaf;
        logic [LEAF_W-2:0] left_leaf;
        logic [LEAF_W-1:0] right_leaf;
    } in_t;

    // Result beat.
    typedef struct packed {
        logic [PRIO_W-1:0] min_priority;
        logic [LEAF_W-1:0] min_leaf;
        logic              empty_res;
        logic              overflow;
        logic [USED_W-1:0] root_count;
    } out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic               load;
        logic               clr;
        logic [NODE_W-1:0]  clr_idx;
        logic [DEPTH_W-1:0] depth;
        logic               side;
        logic [SLOT_W-1:0]  slot;
        logic               bk_rd;
        logic               g_slot;
        logic               g_new;
        logic               r_begin;
        logic               sm_rd;
        logic               sm_right;
        logic               sm_ev;
        logic               sc_rd;
        logic               sc_chk;
        logic               wr_node;
        logic               fin;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic ext;
        logic scan_end;
    } st_t;

    // Node at a given depth on the path of a leaf (heap numbering, root 0).
    function automatic logic [NODE_W-1:0] node_of(input logic [LEAF_W-1:0] pl,
                                                  input logic [DEPTH_W-1:0] depth);
        logic [NODE_W-1:0] t;
        t = {1'b1, pl} >> (DEPTH_W'(LEVELS) - depth);
        return t - NODE_W'(1);
    endfunction

    // True when the node at this depth on the path of pl also lies on the path of lf.
    function automatic logic fits(input logic [LEAF_W-1:0] lf,
                                  input logic [LEAF_W-1:0] pl,
                                  input logic [DEPTH_W-1:0] depth);
        logic [LEAF_W-1:0] x;
        x = (lf ^ pl) >> (DEPTH_W'(LEVELS) - depth);
        return x == '0;
    endfunction

    // Slot count of the node at a depth.
    function automatic logic [SLOT_W-1:0] cap_of(input logic [DEPTH_W-1:0] depth);
        return (depth == '0) ? SLOT_W'(ROOT_SLOTS) : SLOT_W'(BUCKET_SLOTS);
    endfunction

endpackage

FILE: design/popq_ctrl.sv
// Controller: sequences clearing, path gathering and refilling for each command beat.
module popq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  popq_pkg::st_t   st,
    output popq_pkg::cmd_t  cmd,
    output logic            busy
);
    import popq_pkg::*;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_GRD, S_GSLOT, S_GNEW, S_RBEG,
        S_SML, S_SMR, S_SME, S_SCRD, S_SCCK, S_RWR, S_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic               side_reg, side_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [NODE_W-1:0]  clr_reg, clr_next;

    logic               last_side;
    logic [DEPTH_W-1:0] adv_depth;
    logic               adv_side;
    logic [SLOT_W-1:0]  cap;

    // Route stepping: deepest first, alternating between the two insert paths; an extract steps along one path.
    always_comb
    begin
        cap       = cap_of(depth_reg);
        last_side = st.ext || side_reg;
        adv_depth = last_side ? depth_reg - DEPTH_W'(1) : depth_reg;
        adv_side  = !last_side;
    end

    // Next state and commands.
    always_comb
    begin
        state_next  = state_reg;
        depth_next  = depth_reg;
        side_next   = side_reg;
        slot_next   = slot_reg;
        clr_next    = clr_reg;
        cmd         = '0;
        cmd.depth   = depth_reg;
        cmd.side    = side_reg;
        cmd.slot    = slot_reg;
        cmd.clr_idx = clr_reg;
        case (state_reg)
            S_CLR:
            begin
                cmd.clr  = 1'b1;
                clr_next = clr_reg + NODE_W'(1);
                if (clr_reg == NODE_W'(NODES - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    depth_next = DEPTH_W'(LEVELS);
                    side_next  = 1'b0;
                    slot_next  = '0;
                    state_next = S_GRD;
                end
            end
            S_GRD:
            begin
                cmd.bk_rd  = 1'b1;
                slot_next  = '0;
                state_next = S_GSLOT;
            end
            S_GSLOT:
            begin
                cmd.g_slot = 1'b1;
                slot_next  = slot_reg + SLOT_W'(1);
                if (slot_reg == cap - SLOT_W'(1))
                begin
                    slot_next = '0;
                    if (depth_reg == '0)
                    begin
                        depth_next = DEPTH_W'(LEVELS);
                        side_next  = 1'b0;
                        state_next = st.ext ? S_RBEG : S_GNEW;
                    end
                    else
                    begin
                        depth_next = adv_depth;
                        side_next  = adv_side;
                        state_next = (adv_depth == '0) ? S_GSLOT : S_GRD;
                    end
                end
            end
            S_GNEW:
            begin
                cmd.g_new  = 1'b1;
                state_next = S_RBEG;
            end
            S_RBEG:
            begin
                cmd.r_begin = 1'b1;
                state_next  = (depth_reg == DEPTH_W'(LEVELS)) ? S_SCRD : S_SML;
            end
            S_SML:
            begin
                cmd.sm_rd  = 1'b1;
                state_next = S_SMR;
            end
            S_SMR:
            begin
                cmd.sm_ev    = 1'b1;
                cmd.sm_rd    = 1'b1;
                cmd.sm_right = 1'b1;
                state_next   = S_SME;
            end
            S_SME:
            begin
                cmd.sm_ev  = 1'b1;
                state_next = S_SCRD;
            end
            S_SCRD:
            begin
                if (st.scan_end)
                    state_next = S_RWR;
                else
                begin
                    cmd.sc_rd  = 1'b1;
                    state_next = S_SCCK;
                end
            end
            S_SCCK:
            begin
                cmd.sc_chk = 1'b1;
                state_next = S_SCRD;
            end
            S_RWR:
            begin
                cmd.wr_node = 1'b1;
                if (depth_reg == '0)
                    state_next = S_DONE;
                else
                begin
                    depth_next = adv_depth;
                    side_next  = adv_side;
                    state_next = S_RBEG;
                end
            end
            S_DONE:
            begin
                cmd.fin    = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            depth_reg <= '0;
            side_reg  <= 1'b0;
            slot_reg  <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            depth_reg <= depth_next;
            side_reg  <= side_next;
            slot_reg  <= slot_next;
            clr_reg   <= clr_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

FILE: design/popq_dp.sv
// Datapath: bucket, subtree minimum and gather memories, root slots and result register.
module popq_dp (
    input  logic           clk,
    input  logic           rst_n,
    input  popq_pkg::in_t  req,
    input  popq_pkg::cmd_t cmd,
    output popq_pkg::st_t  st,
    output popq_pkg::out_t res,
    output logic           done
);
    import popq_pkg::*;

    // Memories.
    row_t  bucket_mem [NODES-1];
    elem_t sm_mem [NODES];
    elem_t gat_mem [GATHER_MAX];
    row_t  bk_rdata_reg;
    elem_t sm_rdata_reg;
    elem_t gat_rdata_reg;

    // Operation registers.
    in_t                   req_reg;
    logic                  ext_reg;
    elem_t                 res_reg;
    logic                  skip_reg;
    logic [GIDX_W-1:0]     gcnt_reg;
    logic [GIDX_W-1:0]     scan_reg;
    logic [GIDX_W-1:0]     tot_reg;
    logic [SLOT_W-1:0]     take_reg;
    logic [GATHER_MAX-1:0] taken_reg;
    elem_t                 best_reg;
    elem_t                 held_reg [ROOT_SLOTS];
    elem_t                 root_reg [ROOT_SLOTS];
    elem_t                 smroot_reg;
    logic [USED_W-1:0]     used_reg;
    out_t                  out_reg;
    logic                  done_reg;

    logic [LEAF_W-1:0] pa;
    logic [LEAF_W-1:0] pb;
    logic [LEAF_W-1:0] pl;
    logic [NODE_W-1:0] node;
    logic [NODE_W-1:0] row_addr;
    logic [NODE_W-1:0] lc;
    logic [NODE_W-1:0] rc;
    logic [SLOT_W-1:0] cap;
    elem_t             gel;
    elem_t             new_el;
    logic              chk_take;
    row_t              wr_row;

    // Current node on the route and its neighbors.
    always_comb
    begin
        pa       = ext_reg ? res_reg.lf : {1'b0, req_reg.left_leaf};
        pb       = {1'b1, req_reg.right_leaf[LEAF_W-2:0]};
        pl       = cmd.side ? pb : pa;
        node     = node_of(pl, cmd.depth);
        row_addr = node - NODE_W'(1);
        lc       = {node[NODE_W-2:0], 1'b1};
        rc       = lc + NODE_W'(1);
        cap      = cap_of(cmd.depth);
        gel      = (cmd.depth == '0) ? root_reg[cmd.slot[ROOT_IDX_W-1:0]]
                                     : bk_rdata_reg[cmd.slot[BKT_IDX_W-1:0]];
        new_el   = '{prio: req_reg.priority_req, lf: req_reg.leaf};
        chk_take = !taken_reg[scan_reg] && (take_reg < cap)
                   && fits(gat_rdata_reg.lf, pl, cmd.depth);
        for (int j = 0; j < BUCKET_SLOTS; j++)
            wr_row[j] = held_reg[j];
    end

    assign st.ext      = ext_reg;
    assign st.scan_end = (scan_reg == gcnt_reg) || (take_reg == cap);

    // Bucket store: cleared after reset, rewritten one node row per refill step.
    always_ff @(posedge clk)
    begin
        if (cmd.clr && (cmd.clr_idx < NODE_W'(NODES - 1)))
            bucket_mem[cmd.clr_idx] <= '0;
        else if (cmd.wr_node && (cmd.depth != '0))
            bucket_mem[row_addr] <= wr_row;
        if (cmd.bk_rd)
            bk_rdata_reg <= bucket_mem[row_addr];
    end

    // Subtree minimum store.
    always_ff @(posedge clk)
    begin
        if (cmd.clr)
            sm_mem[cmd.clr_idx] <= '{prio: PRIO_NONE, lf: '0};
        else if (cmd.wr_node)
            sm_mem[node] <= best_reg;
        if (cmd.sm_rd)
            sm_rdata_reg <= sm_mem[cmd.sm_right ? rc : lc];
    end

    // Gather list: appended during gathering, scanned in order for each node.
    always_ff @(posedge clk)
    begin
        if ((cmd.g_slot && (gel.prio != '0) && !(skip_reg && (gel == res_reg))))
            gat_mem[gcnt_reg] <= gel;
        else if (cmd.g_new && (new_el.prio != '0) && (new_el.prio != PRIO_NONE))
            gat_mem[gcnt_reg] <= new_el;
        if (cmd.sc_rd)
            gat_rdata_reg <= gat_mem[scan_reg];
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            req_reg <= req;
        if (cmd.r_begin)
        begin
            best_reg <= '{prio: PRIO_NONE, lf: '0};
            for (int j = 0; j < ROOT_SLOTS; j++)
                held_reg[j] <= '0;
        end
        else if (cmd.sm_ev)
        begin
            if ((sm_rdata_reg.prio < best_reg.prio) && (sm_rdata_reg.prio != '0))
                best_reg <= sm_rdata_reg;
        end
        else if (cmd.sc_chk && chk_take)
        begin
            held_reg[take_reg[ROOT_IDX_W-1:0]] <= gat_rdata_reg;
            if (gat_rdata_reg.prio < best_reg.prio)
                best_reg <= gat_rdata_reg;
        end
        if (cmd.load)
            res_reg <= smroot_reg;
        else if (cmd.wr_node && (cmd.depth == '0) && !ext_reg)
            res_reg <= best_reg;
        if (cmd.wr_node && (cmd.depth == '0))
            used_reg <= USED_W'(take_reg);
        if (cmd.fin)
        begin
            out_reg.min_priority <= res_reg.prio;
            out_reg.min_leaf     <= res_reg.lf;
            out_reg.empty_res    <= ext_reg && (res_reg.prio == PRIO_NONE);
            out_reg.overflow     <= (tot_reg != gcnt_reg);
            out_reg.root_count   <= used_reg;
        end
    end

    // Control registers of the operation and the root slots.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_reg    <= 1'b0;
            skip_reg   <= 1'b0;
            gcnt_reg   <= '0;
            scan_reg   <= '0;
            tot_reg    <= '0;
            take_reg   <= '0;
            taken_reg  <= '0;
            smroot_reg <= '{prio: PRIO_NONE, lf: '0};
            done_reg   <= 1'b0;
            for (int j = 0; j < ROOT_SLOTS; j++)
                root_reg[j] <= '0;
        end
        else
        begin
            done_reg <= cmd.fin;
            if (cmd.load)
            begin
                ext_reg   <= req.mode;
                skip_reg  <= req.mode && (smroot_reg.prio != PRIO_NONE);
                gcnt_reg  <= '0;
                tot_reg   <= '0;
                taken_reg <= '0;
            end
            // Append a gathered slot, dropping the first copy of the extracted minimum.
            if (cmd.g_slot && (gel.prio != '0))
            begin
                if (skip_reg && (gel == res_reg))
                    skip_reg <= 1'b0;
                else
                    gcnt_reg <= gcnt_reg + GIDX_W'(1);
            end
            if (cmd.g_new && (new_el.prio != '0) && (new_el.prio != PRIO_NONE))
                gcnt_reg <= gcnt_reg + GIDX_W'(1);
            if (cmd.r_begin)
            begin
                take_reg <= '0;
                scan_reg <= '0;
            end
            if (cmd.sc_chk)
            begin
                scan_reg <= scan_reg + GIDX_W'(1);
                if (chk_take)
                begin
                    taken_reg[scan_reg] <= 1'b1;
                    take_reg            <= take_reg + SLOT_W'(1);
                    tot_reg             <= tot_reg + GIDX_W'(1);
                end
            end
            if (cmd.wr_node && (cmd.depth == '0))
            begin
                smroot_reg <= best_reg;
                for (int j = 0; j < ROOT_SLOTS; j++)
                    root_reg[j] <= held_reg[j];
            end
        end
    end

    assign res  = out_reg;
    assign done = done_reg;

endmodule

FILE: design/path_oblivious_priority_queue_top.sv
// Top level of the path oblivious priority queue: controller and datapath.
//
// A command beat is taken when start is high and busy is low; its single result beat
// appears on res with done high for exactly one cycle, and the receiver cannot stall it.
// After reset the block clears its bucket and subtree minimum memories, one node per
// cycle, with busy high. Each command then keeps busy high while it runs: gathering
// reads the bucket row of each non-root node on the route and appends its occupied
// slots, then the root slots and, for an insert, the new element unless its priority
// is zero or all ones; refilling visits the route deepest first, compares the subtree
// minima of both children at an inner node, scans the gathered elements until the node
// is full or the list ends, and writes the node back.
module path_oblivious_priority_queue_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  popq_pkg::in_t  req,
    output logic           done,
    output popq_pkg::out_t res
);
    import popq_pkg::*;

    cmd_t cmd;
    st_t  st;

    // Sequencer.
    popq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .st    (st),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Storage and element handling.
    popq_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .st    (st),
        .res   (res),
        .done  (done)
    );

endmodule

FILE: dv/tb_path_oblivious_priority_queue_top.sv
// Self-checking testbench for the path oblivious priority queue top level.
`timescale 1ns / 1ps

module tb_path_oblivious_priority_queue_top;

    import popq_pkg::*;

    localparam logic MODE_INSERT  = 1'b0;
    localparam logic MODE_EXTRACT = 1'b1;
    localparam int   HALF         = LEAVES / 2;
    localparam int   RANDOM_OPS   = 1664;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    in_t  req;
    logic done;
    out_t res;

    path_oblivious_priority_queue_top DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .res   (res)
    );

    // Shadow copy of the tree: bucket slots, root slots and per-node minimum.
    elem_t bucket_shadow [(NODES-1)*BUCKET_SLOTS];
    elem_t root_shadow   [ROOT_SLOTS];
    elem_t min_shadow    [NODES];
    int    route_nodes   [$];
    elem_t collected     [$];

    in_t  pending_cmds [$];
    out_t expected_res [$];
    int   idle_pct;
    int   mismatches;
    bit   failed;

    // Clock and reset.
    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    initial
    begin
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Slot access on the shadow tree.
    function automatic elem_t slot_get(input int node, input int j);
        if (node == 0)
            return root_shadow[j];
        return bucket_shadow[(node - 1) * BUCKET_SLOTS + j];
    endfunction

    function automatic void slot_put(input int node, input int j, input elem_t e);
        if (node == 0)
            root_shadow[j] = e;
        else
            bucket_shadow[(node - 1) * BUCKET_SLOTS + j] = e;
    endfunction

    function automatic int slots_at(input int node);
        return (node == 0) ? ROOT_SLOTS : BUCKET_SLOTS;
    endfunction

    // True when the node lies on the leaf-to-root path of the leaf.
    function automatic bit on_path(input int lf, input int node);
        int n;
        n = lf + LEAVES - 1;
        forever
        begin
            if (n == node)
                return 1'b1;
            if (n < node || n == 0)
                return 1'b0;
            n = (n - 1) >> 1;
        end
    endfunction

    // Collect all occupied slots on the route, optionally skipping one element.
    function automatic void collect_route(input bit skip, input elem_t drop);
        elem_t e;
        collected.delete();
        foreach (route_nodes[r])
        begin
            for (int j = 0; j < slots_at(route_nodes[r]); j++)
            begin
                e = slot_get(route_nodes[r], j);
                if (e.prio == '0)
                    continue;
                if (skip && e == drop)
                begin
                    skip = 1'b0;
                    continue;
                end
                collected = {collected, e};
            end
        end
    endfunction

    // Greedy refill deepest first; returns 1 when something was dropped.
    function automatic bit refill_route();
        elem_t held [$];
        elem_t left [$];
        elem_t best;
        elem_t e;
        int    node;
        int    lc;
        int    rc;
        foreach (route_nodes[r])
        begin
            node = route_nodes[r];
            held.delete();
            left.delete();
            foreach (collected[i])
            begin
                if (held.size() < slots_at(node) && on_path(collected[i].lf, node))
                    held = {held, collected[i]};
                else
                    left = {left, collected[i]};
            end
            collected = left;

            // Subtree minimum: left child wins ties, slots must be strictly smaller.
            best = '{prio: PRIO_NONE, lf: '0};
            lc = 2 * node + 1;
            rc = 2 * node + 2;
            if (lc < NODES && min_shadow[lc].prio < best.prio && min_shadow[lc].prio != '0)
                best = min_shadow[lc];
            if (rc < NODES && min_shadow[rc].prio < best.prio && min_shadow[rc].prio != '0)
                best = min_shadow[rc];
            for (int j = 0; j < slots_at(node); j++)
            begin
                e = (j < held.size()) ? held[j] : elem_t'('0);
                if (e.prio != '0 && e.prio < best.prio)
                    best = e;
                slot_put(node, j, e);
            end
            min_shadow[node] = best;
        end
        return collected.size() > 0;
    endfunction

    // Apply one command to the shadow tree and return the expected result beat.
    function automatic out_t predict_queue_op(input in_t cmd);
        out_t  o;
        elem_t top;
        elem_t fresh;
        int    a;
        int    b;
        int    used;
        bit    over;
        route_nodes.delete();
        o = '0;
        if (cmd.mode == MODE_INSERT)
        begin
            a = int'(cmd.left_leaf) % HALF + LEAVES - 1;
            b = HALF + int'(cmd.right_leaf) % HALF + LEAVES - 1;
            while (a > 0 && b > 0)
            begin
                route_nodes = {route_nodes, a};
                route_nodes = {route_nodes, b};
                a = (a - 1) >> 1;
                b = (b - 1) >> 1;
            end
            route_nodes = {route_nodes, 0};
            collect_route(1'b0, min_shadow[0]);
            if (cmd.priority_req != '0 && cmd.priority_req != PRIO_NONE)
            begin
                fresh = '{prio: cmd.priority_req, lf: cmd.leaf};
                collected = {collected, fresh};
            end
            over = refill_route();
            top = min_shadow[0];
        end
        else
        begin
            top = min_shadow[0];
            o.empty_res = (top.prio == PRIO_NONE);
            a = int'(top.lf) + LEAVES - 1;
            while (a > 0)
            begin
                route_nodes = {route_nodes, a};
                a = (a - 1) >> 1;
            end
            route_nodes = {route_nodes, 0};
            collect_route(!o.empty_res, top);
            over = refill_route();
        end
        used = 0;
        foreach (root_shadow[j])
            if (root_shadow[j].prio != '0)
                used++;
        o.min_priority = top.prio;
        o.min_leaf     = top.lf;
        o.overflow     = over;
        o.root_count   = USED_W'(used);
        return o;
    endfunction

    function automatic in_t insert_cmd(input logic [PRIO_W-1:0] p, input int lf,
                                       input int ll, input int rl);
        in_t c;
        c.mode         = MODE_INSERT;
        c.priority_req = p;
        c.leaf         = LEAF_W'(lf);
        c.left_leaf    = (LEAF_W-1)'(ll);
        c.right_leaf   = LEAF_W'(rl);
        return c;
    endfunction

    function automatic in_t extract_cmd();
        in_t c;
        c      = in_t'(($bits(in_t))'({$urandom, $urandom}));
        c.mode = MODE_EXTRACT;
        return c;
    endfunction

    // Random operation; mostly well-formed with a share of ties and ignored priorities.
    function automatic in_t random_cmd();
        logic [PRIO_W-1:0] p;
        int                pick;
        pick = $urandom_range(99);
        if (pick < 42)
            return extract_cmd();
        pick = $urandom_range(99);
        if (pick < 35)
            p = PRIO_W'($urandom_range(20, 1));
        else if (pick < 38)
            p = (pick[0]) ? PRIO_NONE : '0;
        else
            p = PRIO_W'($urandom);
        return insert_cmd(p, $urandom_range(LEAVES - 1), $urandom_range(HALF - 1),
                          $urandom_range(LEAVES - 1));
    endfunction

    // Driver: holds the head command until it is taken, then predicts its result.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            req   <= '0;
        end
        else
        begin
            logic taken;
            taken = start && !busy;
            if (taken)
                expected_res = {expected_res, predict_queue_op(pending_cmds.pop_front())};
            if (start && !taken)
                start <= 1'b1;
            else if (pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                start <= 1'b1;
                req   <= pending_cmds[0];
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: every result beat is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            out_t want;
            if (expected_res.size() == 0)
            begin
                failed = 1'b1;
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result beat: %p", res);
            end
            else
            begin
                want = expected_res.pop_front();
                if (res.min_priority !== want.min_priority || res.min_leaf !== want.min_leaf
                    || res.empty_res !== want.empty_res || res.overflow !== want.overflow
                    || res.root_count !== want.root_count)
                begin
                    failed = 1'b1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %p, got %p", want, res);
                end
            end
        end
    end

    // Safety net against a hung block.
    initial
    begin
        #1_000_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Stimulus in phases of sender idling.
    initial
    begin
        int phase_pct [4] = '{0, 86, 0, 34};
        mismatches = 0;
        failed     = 1'b0;
        idle_pct   = 0;
        foreach (bucket_shadow[i])
            bucket_shadow[i] = '0;
        foreach (root_shadow[i])
            root_shadow[i] = '0;
        foreach (min_shadow[i])
            min_shadow[i] = '{prio: PRIO_NONE, lf: '0};

        // Directed: empty extract, field extremes, ignored priorities, ties.
        pending_cmds = {pending_cmds, extract_cmd()};
        pending_cmds = {pending_cmds, insert_cmd(PRIO_W'(1), 0, 0, LEAVES - 1)};
        pending_cmds = {pending_cmds,
                        insert_cmd(PRIO_NONE - PRIO_W'(1), LEAVES - 1, HALF - 1, HALF)};
        pending_cmds = {pending_cmds, insert_cmd('0, 5, 3, 700)};
        pending_cmds = {pending_cmds, insert_cmd(PRIO_NONE, 6, 4, 0)};
        pending_cmds = {pending_cmds, insert_cmd(PRIO_W'(1), 600, 100, 200)};
        pending_cmds = {pending_cmds, extract_cmd()};
        pending_cmds = {pending_cmds, extract_cmd()};
        pending_cmds = {pending_cmds, extract_cmd()};
        pending_cmds = {pending_cmds, extract_cmd()};
        // Root full: leaf 0 elements with paths that share only two nodes with it.
        for (int i = 0; i < 13; i++)
            pending_cmds = {pending_cmds,
                            insert_cmd(PRIO_W'(100 - i % 3), 0, HALF - 1, LEAVES - 1)};
        pending_cmds = {pending_cmds, extract_cmd()};
        pending_cmds = {pending_cmds, extract_cmd()};
        while (pending_cmds.size() != 0)
            @(posedge clk);

        // Random operations spread over the idling phases.
        foreach (phase_pct[ph])
        begin
            idle_pct = phase_pct[ph];
            for (int i = 0; i < RANDOM_OPS / 4; i++)
                pending_cmds = {pending_cmds, random_cmd()};
            while (pending_cmds.size() != 0)
                @(posedge clk);
        end
        // Drain whatever is left in the queue.
        idle_pct = 0;
        for (int i = 0; i < 60; i++)
            pending_cmds = {pending_cmds, extract_cmd()};
        while (pending_cmds.size() != 0 || expected_res.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (!failed)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
